@@ hw/rtl/tts_pkg.sv @@
// shared types, constants and helpers for the triangular tile back-solve core
package tts_pkg;

    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;
    localparam int HW_LIMIT     = 8;

    localparam int IDX_W   = 3;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 4;
    localparam int PROD_W  = 64;
    localparam int Q_SHIFT = 24;
    localparam int QP_W    = PROD_W - Q_SHIFT;
    localparam int SUM_W   = QP_W + 1;

    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ACT_LD_FAC = 2'd0,
        ACT_LD_RHS = 2'd1,
        ACT_SOLVE  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_X,
        S_MUL_X,
        S_WR_X,
        S_RD_K,
        S_MUL_K,
        S_WR_K,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             ld_fac;
        logic             ld_rhs;
        logic             start;
        logic             rd_x;
        logic             mul_x;
        logic             wr_x;
        logic             rd_k;
        logic             mul_k;
        logic             wr_k;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic             ovf;
        logic [VAL_W-1:0] val;
    } t_sat_res;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    function automatic t_sat_res sat32(input logic signed [SUM_W-1:0] v);
        t_sat_res r;
        if (v > SAT_MAX) begin
            r.ovf = 1'b1;
            r.val = SAT_MAX[VAL_W-1:0];
        end else if (v < SAT_MIN) begin
            r.ovf = 1'b1;
            r.val = SAT_MIN[VAL_W-1:0];
        end else begin
            r.ovf = 1'b0;
            r.val = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tts_ram.sv @@
// generic single-write, single-read ram with registered read data
module tts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tts_ctrl.sv @@
// solve sequencer: config registers, state machine and loop counters
module tts_ctrl #(
    parameter int MAX_ROWS = tts_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tts_pkg::DEF_MAX_COLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [tts_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    input  logic [1:0]                i_action,
    output logic                      o_ready,
    input  tts_pkg::t_stat            i_stat,
    output tts_pkg::t_cmd             o_cmd
);
    import tts_pkg::*;

    localparam logic [CFG_W-1:0] ROW_BOUND =
        (MAX_ROWS < HW_LIMIT) ? CFG_W'(MAX_ROWS) : CFG_W'(HW_LIMIT);
    localparam logic [CFG_W-1:0] COL_BOUND =
        (MAX_COLS < HW_LIMIT) ? CFG_W'(MAX_COLS) : CFG_W'(HW_LIMIT);

    function automatic logic [IDX_W-1:0] last_idx(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] bound);
        logic [CFG_W-1:0] e;
        e = v;
        if (e == '0) begin
            e = CFG_W'(1);
        end
        if (e > bound) begin
            e = bound;
        end
        e = e - CFG_W'(1);
        return e[IDX_W-1:0];
    endfunction

    logic [CFG_W-1:0] r_rows_in_use;
    logic [CFG_W-1:0] r_cols_in_use;
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] w_row_last;
    logic [IDX_W-1:0] w_col_last;

    assign w_row_last = last_idx(r_rows_in_use, ROW_BOUND);
    assign w_col_last = last_idx(r_cols_in_use, COL_BOUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_W'(8);
            r_cols_in_use <= CFG_W'(8);
            r_state       <= S_IDLE;
            r_col         <= '0;
            r_row         <= '0;
            r_k           <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_ROWS) begin
                r_rows_in_use <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_index == CFG_COLS) begin
                r_cols_in_use <= i_cfg_wdata;
            end
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_k     <= n_k;
        end
    end

    // next state and loop counters
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_action == ACT_SOLVE) begin
                    n_col   = w_col_last;
                    n_row   = '0;
                    n_state = S_RD_X;
                end
            end
            S_RD_X:  n_state = S_MUL_X;
            S_MUL_X: n_state = S_WR_X;
            S_WR_X: begin
                n_k     = '0;
                n_state = (r_col == '0) ? S_EMIT : S_RD_K;
            end
            S_RD_K:  n_state = S_MUL_K;
            S_MUL_K: n_state = S_WR_K;
            S_WR_K: begin
                if (r_k == r_col - IDX_W'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = S_RD_K;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    if (r_row == w_row_last) begin
                        if (r_col == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_col   = r_col - IDX_W'(1);
                            n_row   = '0;
                            n_state = S_RD_X;
                        end
                    end else begin
                        n_row   = r_row + IDX_W'(1);
                        n_state = S_RD_X;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.col  = r_col;
        o_cmd.row  = r_row;
        o_cmd.k    = r_k;
        o_cmd.last = (r_col == '0) && (r_row == w_row_last);
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_action)
                        ACT_LD_FAC: o_cmd.ld_fac = 1'b1;
                        ACT_LD_RHS: o_cmd.ld_rhs = 1'b1;
                        ACT_SOLVE:  o_cmd.start  = 1'b1;
                        default:    o_cmd.start  = 1'b0;
                    endcase
                end
            end
            S_RD_X:  o_cmd.rd_x  = 1'b1;
            S_MUL_X: o_cmd.mul_x = 1'b1;
            S_WR_X:  o_cmd.wr_x  = 1'b1;
            S_RD_K:  o_cmd.rd_k  = 1'b1;
            S_MUL_K: o_cmd.mul_k = 1'b1;
            S_WR_K:  o_cmd.wr_k  = 1'b1;
            S_EMIT:  o_cmd.emit  = i_stat.out_free;
            default: o_ready     = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/tts_dp.sv @@
// datapath: factor and rhs memories, multiplier, saturating update, output register
module tts_dp #(
    parameter int MAX_ROWS = tts_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tts_pkg::DEF_MAX_COLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tts_pkg::t_cmd             i_cmd,
    output tts_pkg::t_stat            o_stat,
    input  logic [tts_pkg::IDX_W-1:0] i_index_outer,
    input  logic [tts_pkg::IDX_W-1:0] i_index_inner,
    input  logic [tts_pkg::VAL_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [tts_pkg::IDX_W-1:0] o_out_column,
    output logic [tts_pkg::IDX_W-1:0] o_out_row,
    output logic [tts_pkg::VAL_W-1:0] o_solved_value,
    output logic                      o_last,
    output logic                      o_saturated
);
    import tts_pkg::*;

    localparam int FDIM    = (MAX_COLS < HW_LIMIT) ? MAX_COLS : HW_LIMIT;
    localparam int RDIM    = (MAX_ROWS < HW_LIMIT) ? MAX_ROWS : HW_LIMIT;
    localparam int F_DEPTH = FDIM * FDIM;
    localparam int R_DEPTH = FDIM * RDIM;
    localparam int F_AW    = (F_DEPTH > 1) ? $clog2(F_DEPTH) : 1;
    localparam int R_AW    = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
    localparam int LIM_W   = 5;
    localparam int LIN_W   = 2 * IDX_W + 1;
    localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(MAX_COLS);
    localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(MAX_ROWS);

    // row-major linear address, outer * stride + inner
    function automatic logic [LIN_W-1:0] lin(input logic [IDX_W-1:0] outer,
                                             input logic [IDX_W-1:0] inner,
                                             input logic [LIN_W-1:0] stride);
        return {{(LIN_W-IDX_W){1'b0}}, outer} * stride
             + {{(LIN_W-IDX_W){1'b0}}, inner};
    endfunction

    logic                      w_in_fac_ok;
    logic                      w_in_rhs_ok;
    logic [LIN_W-1:0]          w_f_wlin, w_f_rlin, w_r_wlin, w_r_rlin;
    logic                      w_f_we, w_r_we;
    logic [VAL_W-1:0]          w_r_wdata;
    logic [VAL_W-1:0]          w_f_rdata, w_r_rdata;

    logic signed [PROD_W-1:0]  r_prod;
    logic [VAL_W-1:0]          r_x;
    logic [VAL_W-1:0]          r_old;
    logic                      r_sat;
    logic signed [QP_W-1:0]    w_q;
    logic signed [SUM_W-1:0]   w_diff;
    t_sat_res                  w_x_res, w_y_res;

    logic                      r_out_valid;
    logic [IDX_W-1:0]          r_out_col;
    logic [IDX_W-1:0]          r_out_row;
    logic [VAL_W-1:0]          r_out_val;
    logic                      r_out_last;
    logic                      r_out_sat;

    assign w_in_fac_ok = ({2'b0, i_index_outer} < COLS_LIM) &&
                         ({2'b0, i_index_inner} < COLS_LIM);
    assign w_in_rhs_ok = ({2'b0, i_index_outer} < COLS_LIM) &&
                         ({2'b0, i_index_inner} < ROWS_LIM);

    // factor store: loads only
    assign w_f_we   = i_cmd.ld_fac && w_in_fac_ok;
    assign w_f_wlin = lin(i_index_outer, i_index_inner, LIN_W'(FDIM));
    assign w_f_rlin = i_cmd.rd_k ? lin(i_cmd.col, i_cmd.k, LIN_W'(FDIM))
                                 : lin(i_cmd.col, i_cmd.col, LIN_W'(FDIM));

    // rhs store: loads, solved entry, and updates of earlier columns
    assign w_q    = r_prod[PROD_W-1:Q_SHIFT];
    assign w_diff = {{(SUM_W-VAL_W){r_old[VAL_W-1]}}, r_old} - {w_q[QP_W-1], w_q};
    assign w_x_res = sat32({w_q[QP_W-1], w_q});
    assign w_y_res = sat32(w_diff);

    always_comb begin
        w_r_we    = 1'b0;
        w_r_wlin  = lin(i_index_outer, i_index_inner, LIN_W'(RDIM));
        w_r_wdata = i_value;
        if (i_cmd.ld_rhs) begin
            w_r_we = w_in_rhs_ok;
        end else if (i_cmd.wr_x) begin
            w_r_we    = 1'b1;
            w_r_wlin  = lin(i_cmd.col, i_cmd.row, LIN_W'(RDIM));
            w_r_wdata = w_x_res.val;
        end else if (i_cmd.wr_k) begin
            w_r_we    = 1'b1;
            w_r_wlin  = lin(i_cmd.k, i_cmd.row, LIN_W'(RDIM));
            w_r_wdata = w_y_res.val;
        end
    end

    assign w_r_rlin = i_cmd.rd_k ? lin(i_cmd.k, i_cmd.row, LIN_W'(RDIM))
                                 : lin(i_cmd.col, i_cmd.row, LIN_W'(RDIM));

    tts_ram #(
        .WIDTH  (VAL_W),
        .DEPTH  (F_DEPTH),
        .ADDR_W (F_AW)
    ) u_fac_ram (
        .i_clk   (i_clk),
        .i_we    (w_f_we),
        .i_waddr (w_f_wlin[F_AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (w_f_rlin[F_AW-1:0]),
        .o_rdata (w_f_rdata)
    );

    tts_ram #(
        .WIDTH  (VAL_W),
        .DEPTH  (R_DEPTH),
        .ADDR_W (R_AW)
    ) u_rhs_ram (
        .i_clk   (i_clk),
        .i_we    (w_r_we),
        .i_waddr (w_r_wlin[R_AW-1:0]),
        .i_wdata (w_r_wdata),
        .i_raddr (w_r_rlin[R_AW-1:0]),
        .o_rdata (w_r_rdata)
    );

    // multiplier and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_x) begin
            r_prod <= $signed(w_r_rdata) * $signed(w_f_rdata);
        end else if (i_cmd.mul_k) begin
            r_prod <= $signed(r_x) * $signed(w_f_rdata);
            r_old  <= w_r_rdata;
        end
        if (i_cmd.wr_x) begin
            r_x <= w_x_res.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_sat <= 1'b0;
            end else if (i_cmd.wr_x) begin
                r_sat <= r_sat | w_x_res.ovf;
            end else if (i_cmd.wr_k) begin
                r_sat <= r_sat | w_y_res.ovf;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_col  <= i_cmd.col;
            r_out_row  <= i_cmd.row;
            r_out_val  <= r_x;
            r_out_last <= i_cmd.last;
            r_out_sat  <= r_sat;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_out_column    = r_out_col;
    assign o_out_row       = r_out_row;
    assign o_solved_value  = r_out_val;
    assign o_last          = r_out_last;
    assign o_saturated     = r_out_sat;

endmodule

@@ hw/rtl/triangular_tile_back_solve_core.sv @@
// top level of the triangular tile back-solve core
//
//  channel   | direction | transaction contents
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | load factor entry, load rhs entry or start solve
//  m_axis    | out       | one solved entry, tlast on the final one
//  i_cfg_*   | in        | register write, index 0 rows_in_use, 1 cols_in_use
//
// a load is written while the sequencer stays idle, so the input side stays ready
// a solve occupies the core until its final result is emitted; the single
// multiplier and the one read port of the rhs memory serialize the steps:
// read, multiply, write per reciprocal scaling and per earlier-column update, then emit
// a stalled output holds the sequencer in its emit step; the output register
// lets the next load be taken while the final result is still waiting
// reset (synchronous, active low) clears the sequencer and the output valid and saturation
// flags and sets both config registers to 8; the memory contents are undefined until loaded
module triangular_tile_back_solve_core #(
    parameter int MAX_ROWS = tts_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = tts_pkg::DEF_MAX_COLS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [tts_pkg::CFG_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [39:0]               s_axis_tdata,   // index_outer, index_inner, value, pad
    input  logic [1:0]                s_axis_tuser,   // action
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [39:0]               m_axis_tdata,   // out_column, out_row, solved_value, pad
    output logic                      m_axis_tlast,   // last
    output logic [0:0]                m_axis_tuser    // saturated
);
    import tts_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IDX_W-1:0] w_out_column;
    logic [IDX_W-1:0] w_out_row;
    logic [VAL_W-1:0] w_solved_value;
    logic             w_saturated;

    // sequencer: owns the config registers and the column/row/update loops
    tts_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_action    (s_axis_tuser),
        .o_ready     (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: memories, multiply, q8.24 shift, saturating update
    tts_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_index_outer  (s_axis_tdata[2:0]),
        .i_index_inner  (s_axis_tdata[5:3]),
        .i_value        (s_axis_tdata[37:6]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_out_column   (w_out_column),
        .o_out_row      (w_out_row),
        .o_solved_value (w_solved_value),
        .o_last         (m_axis_tlast),
        .o_saturated    (w_saturated)
    );

    // result packing, lowest field first, zero pad to whole bytes
    assign m_axis_tdata = {2'b00, w_solved_value, w_out_row, w_out_column};
    assign m_axis_tuser = w_saturated;

endmodule

@@ sim/triangular_tile_back_solve_core_tb.sv @@
// self-checking testbench for the triangular tile back-solve core
`timescale 1ns / 100ps

module triangular_tile_back_solve_core_tb;
    import tts_pkg::*;

    localparam int N_DIM       = 8;
    localparam int SETTLE      = 16;         // quiet cycles before a register write
    localparam int TAIL        = 200;        // watch for stray results at the end
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_DIR     = 24;
    localparam int RAND_ITEMS  = 279;

    // the one action code the core must ignore
    localparam logic [1:0] ACT_NOP = 2'd3;

    localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN = 64'shFFFF_FFFF_8000_0000;

    // one input transaction
    typedef struct packed {
        logic [1:0]  act;
        logic [2:0]  outer;
        logic [2:0]  inner;
        logic [31:0] val;
    } t_req;

    // one output transaction, in the order the monitor packs the ports
    typedef struct packed {
        logic [2:0]  col;
        logic [2:0]  row;
        logic [31:0] val;
        logic        last;
        logic        sat;
    } t_solved;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // directed row: a transaction or a register write, with an optional typed expectation
    typedef struct packed {
        t_row_kind   kind;
        logic [0:0]  reg_sel;
        t_req        req;
        logic        typed;
        logic [31:0] want_val;
        logic        want_sat;
    } t_vec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;      // index_outer, index_inner, value, pad
    logic [1:0]  s_axis_tuser = '0;      // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // out_column, out_row, solved_value, pad
    logic        m_axis_tlast;           // last
    logic [0:0]  m_axis_tuser;           // saturated

    // predictor state: factor by (row, column), right-hand side by (column, row)
    logic signed [31:0] fac_mem [N_DIM][N_DIM];
    logic signed [31:0] rhs_mem [N_DIM][N_DIM];
    logic [3:0]         rows_reg = 4'd8;
    logic [3:0]         cols_reg = 4'd8;

    t_solved solved_q [$];               // solved entries still owed by the core
    t_vec    dir_tab [NUM_DIR];

    int errors = 0;
    int cycle_cnt = 0;
    int src_gap_pct = 34;
    int sink_stall_pct = 61;

    triangular_tile_back_solve_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // register value as the core uses it: 0 acts as 1, anything above 8 as 8
    function automatic int clip_size(input logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > N_DIM) return N_DIM;
        return int'(v);
    endfunction

    // q8.24 product, floor division by 2^24
    function automatic longint q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
        return (longint'(a) * longint'(b)) >>> Q_SHIFT;
    endfunction

    function automatic logic signed [31:0] clamp_q(input longint v, inout bit sat);
        if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX[31:0];
        end
        if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // backward column sweep; every solved entry is scaled by the stored reciprocal,
    // written back in place and folded into all earlier columns of the same row
    function automatic void back_substitute(input bit keep);
        int nr;
        int nc;
        bit sat;
        logic signed [31:0] x;
        nr  = clip_size(rows_reg);
        nc  = clip_size(cols_reg);
        sat = 1'b0;
        for (int c = nc - 1; c >= 0; c--) begin
            for (int row = 0; row < nr; row++) begin
                x = clamp_q(q_mul(rhs_mem[c][row], fac_mem[c][c]), sat);
                rhs_mem[c][row] = x;
                for (int k = 0; k < c; k++) begin
                    rhs_mem[k][row] = clamp_q(longint'(rhs_mem[k][row])
                                              - q_mul(x, fac_mem[c][k]), sat);
                end
                if (keep) begin
                    solved_q.push_back(t_solved'{3'(c), 3'(row), x,
                                                 (c == 0 && row == nr - 1), sat});
                end
            end
        end
    endfunction

    // update the predictor for one accepted transaction
    function automatic void apply_req(input t_req r);
        case (r.act)
            ACT_LD_FAC: fac_mem[r.outer][r.inner] = r.val;
            ACT_LD_RHS: rhs_mem[r.outer][r.inner] = r.val;
            ACT_SOLVE:  back_substitute(1'b1);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_solved got;
        t_solved want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got = {m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6],
                   m_axis_tlast, m_axis_tuser[0]};
            if (solved_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none,", $time,
                         " got col %0d row %0d val %h last %b sat %b",
                         got.col, got.row, got.val, got.last, got.sat);
            end else begin
                want = solved_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch: expected col %0d row %0d val %h last %b sat %b,",
                             $time, want.col, want.row, want.val, want.last, want.sat,
                             " got col %0d row %0d val %h last %b sat %b",
                             got.col, got.row, got.val, got.last, got.sat);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one transaction, returns in the time step of its acceptance;
    // valid stays up until the next falling edge decides on more data or a gap
    task automatic push_item(input t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.val, r.inner, r.outer};
        s_axis_tuser  <= r.act;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
    endtask

    // hold off the input until every owed result has been delivered
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (solved_q.size() != 0) @(negedge i_clk);
    endtask

    // register writes only land on an idle core
    task automatic write_reg(input logic [0:0] sel, input logic [3:0] data);
        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_wdata <= data;
        if (sel == CFG_ROWS) rows_reg = data;
        else cols_reg = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus shaping
    // ------------------------------------------------------------------

    function automatic logic [31:0] rand_sign(input logic [31:0] mag);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // reciprocals near one, small off-diagonal terms, now and then raw bits
    function automatic logic [31:0] pick_factor(input logic [2:0] o, input logic [2:0] i);
        if ($urandom_range(99) < 15) return $urandom();
        if (o == i) return rand_sign($urandom_range(32'h0180_0000, 32'h0080_0000));
        return rand_sign($urandom_range(32'h0040_0000, 0));
    endfunction

    function automatic logic [31:0] pick_rhs();
        if ($urandom_range(99) < 15) return $urandom();
        return rand_sign($urandom_range(32'h1000_0000, 0));
    endfunction

    function automatic logic [3:0] pick_size();
        logic [3:0] corner [4] = '{4'd0, 4'd1, 4'd8, 4'd15};
        if ($urandom_range(99) < 30) return corner[$urandom_range(3)];
        return 4'($urandom());
    endfunction

    // now and then resize, reload part of the tiles, throw in some ignored codes, then solve
    task automatic random_episode(inout int sent);
        int   n_loads;
        int   sel;
        t_req r;
        n_loads = $urandom_range(16, 0);
        if ($urandom_range(99) < 40) begin
            if ($urandom_range(1)) write_reg(CFG_ROWS, pick_size());
            if ($urandom_range(1)) write_reg(CFG_COLS, pick_size());
        end
        repeat (n_loads) begin
            r.outer = 3'($urandom());
            r.inner = 3'($urandom());
            sel     = $urandom_range(99);
            if (sel < 10) begin
                r.act = ACT_NOP;
                r.val = $urandom();
            end else if (sel < 55) begin
                r.act = ACT_LD_FAC;
                r.val = pick_factor(r.outer, r.inner);
            end else begin
                r.act = ACT_LD_RHS;
                r.val = pick_rhs();
            end
            push_item(r);
            apply_req(r);
            sent++;
        end
        r = t_req'{ACT_SOLVE, 3'($urandom()), 3'($urandom()), $urandom()};
        push_item(r);
        apply_req(r);
        sent++;
    endtask

    // directed row builders
    function automatic t_vec item(input logic [1:0] act, input logic [2:0] o,
                                  input logic [2:0] i, input logic [31:0] v);
        return t_vec'{ROW_ITEM, 1'b0, t_req'{act, o, i, v}, 1'b0, 32'd0, 1'b0};
    endfunction

    // 1x1 solve whose single result is known at a glance
    function automatic t_vec solve_is(input logic [31:0] v, input logic s);
        return t_vec'{ROW_ITEM, 1'b0, t_req'{ACT_SOLVE, 3'd0, 3'd0, 32'd0}, 1'b1, v, s};
    endfunction

    function automatic t_vec reg_wr(input logic [0:0] sel, input logic [3:0] d);
        return t_vec'{ROW_REG, sel, t_req'{2'd0, 3'd0, 3'd0, {28'd0, d}}, 1'b0, 32'd0, 1'b0};
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int   sent;
        int   gap_pct [3];
        int   stall_pct [3];
        t_req r;

        gap_pct   = '{34, 61, 0};
        stall_pct = '{61, 34, 0};

        dir_tab = '{
            // zero in both registers acts as a 1x1 tile
            reg_wr(CFG_ROWS, 4'd0),
            reg_wr(CFG_COLS, 4'd0),
            // unit reciprocal passes the entry through
            item(ACT_LD_FAC, 3'd0, 3'd0, 32'h0100_0000),
            item(ACT_LD_RHS, 3'd0, 3'd0, 32'h1234_5678),
            solve_is(32'h1234_5678, 1'b0),
            // positive and negative saturation
            item(ACT_LD_FAC, 3'd0, 3'd0, 32'h7FFF_FFFF),
            item(ACT_LD_RHS, 3'd0, 3'd0, 32'h7FFF_FFFF),
            solve_is(32'h7FFF_FFFF, 1'b1),
            item(ACT_LD_RHS, 3'd0, 3'd0, 32'h8000_0000),
            solve_is(32'h8000_0000, 1'b1),
            // solve again without reloading: works on the stored solution
            solve_is(32'h8000_0000, 1'b1),
            // smallest negative reciprocal, sign flip of the most negative entry
            item(ACT_LD_FAC, 3'd0, 3'd0, 32'hFFFF_FFFF),
            solve_is(32'h0000_0080, 1'b0),
            // floor rounding of a tiny negative product
            item(ACT_LD_RHS, 3'd0, 3'd0, 32'h0000_0001),
            solve_is(32'hFFFF_FFFF, 1'b0),
            // unused action code, no result
            item(ACT_NOP, 3'd7, 3'd7, 32'hFFFF_FFFF),
            // entry above the diagonal is stored but never read
            item(ACT_LD_FAC, 3'd0, 3'd7, 32'hDEAD_BEEF),
            item(ACT_LD_FAC, 3'd0, 3'd0, 32'h0100_0000),
            // out-of-range registers clamp to the full 8x8 tile
            reg_wr(CFG_ROWS, 4'd15),
            reg_wr(CFG_COLS, 4'd9),
            item(ACT_SOLVE, 3'd0, 3'd0, 32'd0),
            reg_wr(CFG_ROWS, 4'd8),
            reg_wr(CFG_COLS, 4'd1),
            item(ACT_SOLVE, 3'd7, 3'd7, 32'hFFFF_FFFF)
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill both stores so no solve ever reads an entry that was never written
        for (int o = 0; o < N_DIM; o++) begin
            for (int i = 0; i < N_DIM; i++) begin
                r = t_req'{ACT_LD_FAC, 3'(o), 3'(i), pick_factor(3'(o), 3'(i))};
                push_item(r);
                apply_req(r);
                r = t_req'{ACT_LD_RHS, 3'(o), 3'(i), pick_rhs()};
                push_item(r);
                apply_req(r);
            end
        end

        // directed rows, typed expectations where the answer is obvious
        foreach (dir_tab[n]) begin
            if (dir_tab[n].kind == ROW_REG) begin
                write_reg(dir_tab[n].reg_sel, dir_tab[n].req.val[3:0]);
            end else begin
                push_item(dir_tab[n].req);
                if (dir_tab[n].typed) begin
                    // keep the predictor's stores in step, but owe the typed result
                    back_substitute(1'b0);
                    solved_q.push_back(t_solved'{3'd0, 3'd0, dir_tab[n].want_val,
                                                 1'b1, dir_tab[n].want_sat});
                end else begin
                    apply_req(dir_tab[n].req);
                end
            end
        end

        // random part in three idling regimes; each switch first empties the core
        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            drain_results();
            src_gap_pct    = gap_pct[ph];
            sink_stall_pct = stall_pct[ph];
            while (sent < (ph + 1) * RAND_ITEMS / 3) random_episode(sent);
        end

        drain_results();
        repeat (TAIL) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
